[rtl/msl_pkg.sv]
// shared types, constants and helpers for the multichannel motor slew limiter
package msl_pkg;

  localparam int NUM_CHANNELS_DEF = 10;
  localparam int CHAN_W           = 4;
  localparam int LEVEL_W          = 8;
  localparam int CFG_W            = 8;

  localparam logic [CFG_W-1:0] STEP_LIMIT_RESET = 8'd15;
  localparam logic [CFG_W-1:0] DEADBAND_RESET   = 8'd15;

  typedef enum logic {
    KIND_SET  = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic {
    CFG_STEP_LIMIT = 1'b0,
    CFG_DEADBAND   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    kind_t                      kind;
    logic [CHAN_W-1:0]          channel;
    logic signed [LEVEL_W-1:0]  command;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]          out_channel;
    logic signed [LEVEL_W-1:0]  drive;
    logic                       last;
  } out_item_t;

  // command magnitude below the deadband becomes zero
  function automatic logic signed [LEVEL_W-1:0] apply_deadband(
    input logic signed [LEVEL_W-1:0] cmd,
    input logic [CFG_W-1:0]          band
  );
    logic [LEVEL_W:0] mag;
    begin
      mag = cmd[LEVEL_W-1] ? (LEVEL_W+1)'(-$signed({cmd[LEVEL_W-1], cmd}))
                           : {1'b0, cmd};
      apply_deadband = (mag < {1'b0, band}) ? '0 : cmd;
    end
  endfunction

endpackage

[rtl/msl_slew_unit.sv]
// shared slew step: moves one drive level toward its target by at most the step limit
module msl_slew_unit
  import msl_pkg::*;
(
  input  logic signed [LEVEL_W-1:0] target,
  input  logic signed [LEVEL_W-1:0] drive,
  input  logic [CFG_W-1:0]          step_limit,
  output logic signed [LEVEL_W-1:0] new_drive
);

  logic signed [LEVEL_W:0] diff;
  logic [LEVEL_W:0]        mag;
  logic [LEVEL_W:0]        step;
  logic signed [LEVEL_W:0] sum;

  always_comb begin
    diff = $signed({target[LEVEL_W-1], target}) - $signed({drive[LEVEL_W-1], drive});
    mag  = diff[LEVEL_W] ? (LEVEL_W+1)'(-diff) : diff;
    step = ({1'b0, step_limit} < mag) ? {1'b0, step_limit} : mag;
    sum  = diff[LEVEL_W] ? $signed({drive[LEVEL_W-1], drive}) - $signed(step)
                         : $signed({drive[LEVEL_W-1], drive}) + $signed(step);
    new_drive = sum[LEVEL_W-1:0];
  end

endmodule

[rtl/multichannel_motor_slew_limiter.sv]
// top level: per-channel target and drive stores, sequencer around the shared slew unit
//
// usage
// - in channel: in_valid/in_ready/in_data. a set beat writes one channel's
//   target (deadband applied) in the cycle it is accepted and gives no result;
//   a set beat for a channel at or above NUM_CHANNELS is dropped
// - a tick beat starts a walk over channels 0 to NUM_CHANNELS-1; each channel
//   passes through ST_CALC in the slew unit and then ST_SEND, where its result
//   stays on out_data until out_ready; the last beat carries last = 1
// - in_ready stays low for the whole walk; the walk simply waits while
//   out_ready is low, nothing is lost
// - cfg channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; the user
//   must have it written only while the block is idle, the block does not enforce this
// - reset: synchronous, active low; clears all targets and drive levels,
//   loads step_limit 15 and deadband 15, no result pending
module multichannel_motor_slew_limiter
  import msl_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);
  localparam logic [CHAN_W:0]  NUM_CH   = (CHAN_W+1)'(NUM_CHANNELS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SEND
  } state_t;

  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  out_item_t                 out_r, out_nxt;
  logic [CFG_W-1:0]          step_limit_r;
  logic [CFG_W-1:0]          deadband_r;
  logic signed [LEVEL_W-1:0] target_r [NUM_CHANNELS];
  logic signed [LEVEL_W-1:0] drive_r  [NUM_CHANNELS];

  logic                      in_beat;
  logic                      set_ok;
  logic signed [LEVEL_W-1:0] new_drive;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SEND);
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;
  assign set_ok    = in_beat && (in_data.kind == KIND_SET) &&
                     ({1'b0, in_data.channel} < NUM_CH);

  msl_slew_unit u_slew (
    .target     (target_r[idx_r]),
    .drive      (drive_r[idx_r]),
    .step_limit (step_limit_r),
    .new_drive  (new_drive)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    out_nxt   = out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat && (in_data.kind == KIND_TICK)) begin
          idx_nxt   = '0;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        out_nxt.out_channel = CHAN_W'(idx_r);
        out_nxt.drive       = new_drive;
        out_nxt.last        = (idx_r == LAST_IDX);
        state_nxt           = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) begin
          if (out_r.last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_CALC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_limit_r <= STEP_LIMIT_RESET;
      deadband_r   <= DEADBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP_LIMIT: step_limit_r <= cfg_data;
        CFG_DEADBAND:   deadband_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        target_r[i] <= '0;
        drive_r[i]  <= '0;
      end
    end else begin
      if (set_ok) begin
        target_r[in_data.channel[IDX_W-1:0]] <= apply_deadband(in_data.command, deadband_r);
      end
      if (state_r == ST_CALC) begin
        drive_r[idx_r] <= new_drive;
      end
    end
  end

endmodule

[verif/slew_checker.sv]
`timescale 1ns / 1ps
// slew limiter checker: tracks targets, drive levels and config, predicts and compares drive reports
module slew_checker
  import msl_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  logic signed [LEVEL_W-1:0] target_lvl [NUM_CHANNELS];
  logic signed [LEVEL_W-1:0] drive_lvl [NUM_CHANNELS];
  logic [CFG_W-1:0]          step_limit_q;
  logic [CFG_W-1:0]          deadband_q;
  out_item_t                 drive_reports[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    if (fail_count < 200) $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : track
    out_item_t want;
    int        c;
    int        diff;
    int        stp;
    int        lvl;
    int        mag;
    if (!rst_n) begin
      for (c = 0; c < NUM_CHANNELS; c++) begin
        target_lvl[c] = '0;
        drive_lvl[c] = '0;
      end
      step_limit_q = STEP_LIMIT_RESET;
      deadband_q = DEADBAND_RESET;
      drive_reports.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (drive_reports.size() == 0) begin
          report($sformatf("unexpected beat channel %0d drive %0d last %0b",
                           out_data.out_channel, out_data.drive, out_data.last));
        end else begin
          want = drive_reports.pop_front();
          if (out_data.out_channel !== want.out_channel)
            report($sformatf("channel got %0d want %0d",
                             out_data.out_channel, want.out_channel));
          if (out_data.drive !== want.drive)
            report($sformatf("drive on channel %0d got %0d want %0d",
                             want.out_channel, out_data.drive, want.drive));
          if (out_data.last !== want.last)
            report($sformatf("last on channel %0d got %0b want %0b",
                             want.out_channel, out_data.last, want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP_LIMIT: step_limit_q = cfg_data;
          CFG_DEADBAND:   deadband_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.kind == KIND_SET) begin
          if (int'(in_data.channel) < NUM_CHANNELS) begin
            mag = int'($signed(in_data.command));
            if (mag < 0) mag = -mag;
            target_lvl[in_data.channel] = (mag < int'(deadband_q)) ? '0 : in_data.command;
          end
        end else begin
          // tick: walk every channel toward its target
          for (c = 0; c < NUM_CHANNELS; c++) begin
            diff = int'(target_lvl[c]) - int'(drive_lvl[c]);
            if (diff != 0) begin
              stp = (diff < 0) ? -diff : diff;
              if (int'(step_limit_q) < stp) stp = int'(step_limit_q);
              lvl = int'(drive_lvl[c]) + ((diff > 0) ? stp : -stp);
              drive_lvl[c] = LEVEL_W'(lvl);
            end
            want.out_channel = CHAN_W'(c);
            want.drive = drive_lvl[c];
            want.last = (c == NUM_CHANNELS - 1);
            drive_reports.push_back(want);
          end
        end
      end
    end
    pending = drive_reports.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// testbench top for the slew limiter: clock, reset, stimulus, result sink, watchdog and verdict
module tb;
  import msl_pkg::*;

  localparam int NCH        = NUM_CHANNELS_DEF;
  localparam int HOLD_LEN   = 150;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 2 * NCH + 4;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int               fail_count;
  int               pending;
  int               in_gap_max = 0;
  int               out_gap_max = 0;
  int               hold_asked = 0;
  int               hold_given = 0;
  int               idle_cycles = 0;
  logic [CFG_W-1:0] band_now;

  multichannel_motor_slew_limiter #(
    .NUM_CHANNELS(NCH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  slew_checker #(
    .NUM_CHANNELS(NCH)
  ) drive_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result sink with random stalls and an occasional long hold-off
  initial begin : sink
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_given < hold_asked) begin
        gap = HOLD_LEN;
        hold_given++;
      end else begin
        gap = $urandom_range(out_gap_max, 0);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input kind_t k, input logic [CHAN_W-1:0] ch,
                           input logic [LEVEL_W-1:0] cmd);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= '{kind: k, channel: ch, command: cmd};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] band);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_index <= CFG_STEP_LIMIT;
    cfg_data <= step;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_DEADBAND;
    cfg_data <= band;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    band_now = band;
  endtask

  initial begin : stimulus
    int                 p;
    int                 i;
    int                 roll;
    int                 mag;
    logic [LEVEL_W-1:0] cmd;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_STEP_LIMIT;
    cfg_data = '0;
    band_now = DEADBAND_RESET;
    out_gap_max = 16;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes, deadband edges, out of range channels
    send_item(KIND_SET, 4'd0, 8'h7f);
    send_item(KIND_SET, 4'd1, 8'h80);
    send_item(KIND_SET, 4'd2, 8'h0e);
    send_item(KIND_SET, 4'd3, 8'hf1);
    send_item(KIND_SET, 4'd8, 8'haa);
    send_item(KIND_SET, 4'd9, 8'h55);
    send_item(KIND_SET, 4'd10, 8'h32);
    send_item(KIND_SET, 4'd15, 8'hff);
    send_item(KIND_TICK, 4'd15, 8'h80);
    send_item(KIND_TICK, 4'd0, 8'h00);
    send_item(KIND_SET, 4'd4, 8'hff);
    send_item(KIND_SET, 4'd5, 8'h10);
    send_item(KIND_TICK, 4'd5, 8'h7f);

    // widest step lands on target, full deadband keeps only -128
    set_config(8'd255, 8'd128);
    send_item(KIND_SET, 4'd0, 8'h80);
    send_item(KIND_SET, 4'd1, 8'h7f);
    send_item(KIND_SET, 4'd2, 8'h81);
    send_item(KIND_TICK, 4'd7, 8'h11);
    send_item(KIND_TICK, 4'd3, 8'h22);

    // zero step freezes all drive levels
    set_config(8'd0, 8'd0);
    send_item(KIND_SET, 4'd6, 8'h01);
    send_item(KIND_TICK, 4'd9, 8'hee);

    // deadband beyond full scale zeroes every command
    in_gap_max = 16;
    set_config(8'd7, 8'd200);
    send_item(KIND_SET, 4'd0, 8'h80);
    send_item(KIND_SET, 4'd7, 8'h7f);
    send_item(KIND_TICK, 4'd12, 8'h5a);
    send_item(KIND_TICK, 4'd1, 8'ha5);

    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_config(8'd255, 8'd0);
        1: set_config(8'd0, 8'd128);
        2: set_config(8'd1, 8'd64);
        default: set_config(CFG_W'($urandom_range(255, 0)), CFG_W'($urandom_range(128, 0)));
      endcase
      in_gap_max = (p % 3 == 1) ? 0 : 16;
      out_gap_max = (p % 2 == 1) ? 0 : 16;
      for (i = 0; i < 48; i++) begin
        roll = $urandom_range(99, 0);
        if (p == 3 && i == 16) begin
          // long sink stall while ticks keep coming
          hold_asked++;
          roll = 0;
        end
        if (p == 4 && i == 24) drain();
        if (roll < 30) begin
          send_item(KIND_TICK, CHAN_W'($urandom()), LEVEL_W'($urandom()));
        end else if (roll < 38) begin
          send_item(KIND_SET, CHAN_W'($urandom_range(15, NCH)), LEVEL_W'($urandom()));
        end else begin
          case ($urandom_range(3, 0))
            0: cmd = $urandom_range(1, 0) ? 8'h7f : 8'h80;
            1: begin
              mag = int'(band_now) + $urandom_range(2, 0) - 1;
              if (mag < 0) mag = 0;
              if (mag > 128) mag = 128;
              cmd = $urandom_range(1, 0) ? LEVEL_W'(-mag) : LEVEL_W'(mag);
            end
            default: cmd = LEVEL_W'($urandom());
          endcase
          send_item(KIND_SET, CHAN_W'($urandom_range(NCH - 1, 0)), cmd);
        end
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
